// ===== design/olid_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ordered list block.
// No dependencies; imported by every module of the block.
package olid_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    localparam logic [1:0] WHERE_FRONT = 2'd0;
    localparam logic [1:0] WHERE_POS   = 2'd1;
    localparam logic [1:0] WHERE_END   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic    shift_ins;
        logic    shift_del;
        logic    idx_inc;
        logic    idx_clr;
        logic    rd_from_idx;
        logic    out_load;
        logic    out_zero;
        logic    out_last;
        status_t out_status;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic ins_ok;
        logic del_ok;
        logic stream_last;
        logic out_free;
    } stat_t;

endpackage

// ===== design/olid_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer: decodes the request and issues datapath commands.
// Depends on olid_pkg.
module olid_ctrl import olid_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] req_type,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.out_status = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = 1'b1;
                    cmd.out_last = 1'b1;
                    unique case (req_t'(req_type))
                        REQ_INSERT: begin
                            if (stat.full) begin
                                cmd.out_status = ST_FULL;
                            end else if (!stat.ins_ok) begin
                                cmd.out_status = ST_RANGE;
                            end else begin
                                cmd.shift_ins = 1'b1;
                            end
                        end
                        REQ_DELETE: begin
                            if (stat.empty) begin
                                cmd.out_status = ST_EMPTY;
                            end else if (!stat.del_ok) begin
                                cmd.out_status = ST_RANGE;
                            end else begin
                                cmd.shift_del = 1'b1;
                                cmd.out_zero  = 1'b0;
                            end
                        end
                        REQ_READ: begin
                            if (stat.empty) begin
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.rd_from_idx = 1'b1;
                                cmd.out_zero    = 1'b0;
                                cmd.out_last    = stat.stream_last;
                                if (!stat.stream_last) begin
                                    cmd.idx_inc = 1'b1;
                                    state_next  = S_STREAM;
                                end
                            end
                        end
                        default: begin
                            cmd.out_status = ST_OK;
                        end
                    endcase
                end
            end
            S_STREAM: begin
                if (stat.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.rd_from_idx = 1'b1;
                    cmd.out_last    = stat.stream_last;
                    if (stat.stream_last) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/olid_dp.sv =====
`timescale 1ns / 1ps
// Datapath: shifting cell file, element count, read-out index, result register.
// Depends on olid_pkg.
module olid_dp import olid_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [1:0]               where_code,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [DATA_W-1:0] m_data,
    output logic                     m_last
);

    logic [DATA_W-1:0] cell_reg  [DEPTH];
    logic [DATA_W-1:0] cell_next [DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [CMP_W-1:0]  cnt_x, pos_x, ins_slot_x, del_slot_x;
    logic [IDX_W-1:0]  ins_slot, del_slot, rd_addr;
    logic              ins_ok, del_ok;
    logic [DATA_W-1:0] rd_data;

    assign cnt_x = CMP_W'(count_reg);
    assign pos_x = CMP_W'(position);

    // Slot decode for insert (limit count+1) and delete (limit count)
    always_comb begin
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        ins_slot_x = '0;
        del_slot_x = '0;
        unique case (where_code)
            WHERE_FRONT: begin
                ins_ok = 1'b1;
                del_ok = 1'b1;
            end
            WHERE_END: begin
                ins_ok     = 1'b1;
                del_ok     = 1'b1;
                ins_slot_x = cnt_x;
                del_slot_x = cnt_x - CMP_W'(1);
            end
            WHERE_POS: begin
                ins_ok     = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
                del_ok     = (pos_x != '0) && (pos_x <= cnt_x);
                ins_slot_x = pos_x - CMP_W'(1);
                del_slot_x = pos_x - CMP_W'(1);
            end
            default: begin
                ins_ok = 1'b0;
                del_ok = 1'b0;
            end
        endcase
    end

    assign ins_slot = ins_slot_x[IDX_W-1:0];
    assign del_slot = del_slot_x[IDX_W-1:0];
    assign rd_addr  = cmd.rd_from_idx ? idx_reg : del_slot;
    assign rd_data  = cell_reg[rd_addr];

    assign stat.empty       = (count_reg == '0);
    assign stat.full        = (count_reg == CNT_W'(DEPTH));
    assign stat.ins_ok      = ins_ok;
    assign stat.del_ok      = del_ok;
    assign stat.stream_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign stat.out_free    = !out_valid_reg || m_ready;

    // Above ins_slot a cell takes its left neighbor; from del_slot, its right
    for (genvar gk = 0; gk < DEPTH; gk++) begin : g_cell
        always_comb begin
            cell_next[gk] = cell_reg[gk];
            if (cmd.shift_ins) begin
                if (IDX_W'(gk) == ins_slot) begin
                    cell_next[gk] = value;
                end else if (IDX_W'(gk) > ins_slot) begin
                    if (gk > 0) begin
                        cell_next[gk] = cell_reg[(gk > 0) ? gk - 1 : 0];
                    end
                end
            end else if (cmd.shift_del) begin
                if ((IDX_W'(gk) >= del_slot) && (gk < DEPTH - 1)) begin
                    cell_next[gk] = cell_reg[(gk < DEPTH - 1) ? gk + 1 : gk];
                end
            end
        end

        always_ff @(posedge aclk) begin
            cell_reg[gk] <= cell_next[gk];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.shift_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.shift_del) begin
            count_next = count_reg - CNT_W'(1);
        end
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            out_data_reg   <= cmd.out_zero ? '0 : rd_data;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_data   = out_data_reg;
    assign m_last   = out_last_reg;

endmodule

// ===== design/ordered_list_insert_delete.sv =====
`timescale 1ns / 1ps
// Top level of the ordered list block: sequencer plus datapath.
// Depends on olid_pkg, olid_ctrl and olid_dp.
//
//  Channel | Direction | Ports                                      | Handshake
//  s_      | in        | s_req_type s_where s_position s_value      | s_valid / s_ready
//  m_      | out       | m_status m_data m_last                     | m_valid / m_ready
//
// Insert, delete, unused codes: one item per cycle unless stalled, one result each.
// Read out: one listed element per cycle unless stalled; the single
// read port of the cell file and the result register set that pace.
// Reset (aresetn low, synchronous) clears the count, index and result valid;
// cell contents are left as they are and never read before being written.
// A held result stalls the block; the next item is taken in the cycle that
// result leaves, and none is taken while a read out is streaming.
module ordered_list_insert_delete import olid_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_req_type,
    input  logic [1:0]               s_where,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [DATA_W-1:0] m_data,
    output logic                     m_last
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer: decode the request, walk the list during a read out
    olid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: shift cells, track count, hold the result item
    olid_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .where_code (s_where),
        .position   (s_position),
        .value      (s_value),
        .cmd        (cmd),
        .stat       (stat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_data     (m_data),
        .m_last     (m_last)
    );

    // Insert into a full list must report full and change nothing
    a_full_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_INSERT) && stat.full)
        |=> (m_valid && (m_status == ST_FULL) && m_last && stat.full))
        else $error("insert into full list not reported");

    // Delete from an empty list must report empty with zero data
    a_empty_delete: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_DELETE) && stat.empty)
        |=> (m_valid && (m_status == ST_EMPTY) && (m_data == '0) && stat.empty))
        else $error("delete from empty list not reported");

    // No new item while a read out is still mid-stream
    a_stream_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> !s_ready)
        else $error("item accepted during read out");

endmodule
